/* rtl/positional_list_store_unit_assert.svh */
// Assertion macros used by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLSU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/plsu_pkg.sv */
// Shared types, operation codes and status codes of the positional list store.
package plsu_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int FUNC_W       = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int ECOUNT_W     = 5;

    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_END   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;
    localparam logic [FUNC_W-1:0] FN_TRAVERSE  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          position;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] out_value;
        logic [ECOUNT_W-1:0]       element_count;
        logic                      last;
    } t_out_word;

endpackage

/* rtl/positional_list_store_unit.sv */
// Positional list store: ordered list of signed words kept in one synchronous memory.
//
// A request word enters on the input channel (i_in_valid, o_in_stall) and
// carries an operation, a value and a 1-based position. Inserts and deletes
// shift the entries behind the affected slot one place through the memory,
// one entry per cycle, with the read of the next entry overlapping the write
// of the previous one. A traversal reads each entry and loads it as a result
// word before reading the next, emitting one result word per element, with
// last set on the final one. Errors, an empty traversal and an unused
// operation code give a single result word.
// Results leave through an output register (o_out_valid, i_out_stall); while
// the receiver stalls, the word there holds and the sequencer waits before
// loading the next one. One request is in progress at a time; o_in_stall is
// high from acceptance until its final result word is loaded.
// Reset empties the list and clears the output valid flag; memory contents
// are left as they are, since only entries below the count are ever read.
module positional_list_store_unit
    import plsu_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_DEL     = 3'd2;
    localparam logic [2:0] S_TRAV_RD = 3'd3;
    localparam logic [2:0] S_TRAV_WT = 3'd4;
    localparam logic [2:0] S_RESULT  = 3'd5;

    // Entry storage: one write port, one read port with registered data.
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rd_q;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_wa, n_wa;
    logic                r_pend, n_pend;
    logic [VALUE_W-1:0]  r_val, n_val;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic          in_accept;
    logic          out_free;
    logic          out_load;
    t_out_word     out_next;
    logic          full;
    logic          empty;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] ptr_inc;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign pos_x     = CMPW'(i_in_word.position);
    assign cnt_x     = CMPW'(r_count);
    assign ptr_dec   = r_ptr - CW'(1);
    assign ptr_inc   = r_ptr + CW'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_idx    = r_idx;
        n_wa     = r_wa;
        n_pend   = r_pend;
        n_val    = r_val;
        n_status = r_status;
        rd_en    = 1'b0;
        rd_addr  = r_ptr[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_wa;
        wr_data  = rd_q;
        out_load = 1'b0;
        out_next.status        = r_status;
        out_next.out_value     = '0;
        out_next.element_count = ECOUNT_W'(r_count);
        out_next.last          = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_val    = i_in_word.item_value;
                    n_pend   = 1'b0;
                    n_status = ST_OK;
                    n_ptr    = r_count;
                    n_state  = S_RESULT;
                    unique case (i_in_word.func)
                        FN_INS_FRONT, FN_INS_END: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = (i_in_word.func == FN_INS_FRONT) ? '0 : r_count;
                                n_state = S_INS;
                            end
                        end
                        FN_INS_AT: begin
                            priority if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                                n_status = ST_BADPOS;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_idx   = CW'(pos_x - CMPW'(1));
                                n_state = S_INS;
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_END: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // The read pointer starts one slot behind the removed one.
                                n_ptr   = (i_in_word.func == FN_DEL_FRONT) ? CW'(1) : r_count;
                                n_state = S_DEL;
                            end
                        end
                        FN_DEL_AT: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_ptr   = CW'(pos_x);
                                n_state = S_DEL;
                            end
                        end
                        FN_TRAVERSE: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_TRAV_RD;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INS: begin
                // Move entries up from the tail; each read lands one slot higher next cycle.
                wr_en = r_pend;
                priority if (r_ptr != r_idx) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_dec[AW-1:0];
                    n_wa    = r_ptr[AW-1:0];
                    n_ptr   = ptr_dec;
                    n_pend  = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx[AW-1:0];
                    wr_data = r_val;
                    n_count = r_count + CW'(1);
                    n_state = S_RESULT;
                end
            end
            S_DEL: begin
                // Move entries down toward the removed slot, one per cycle.
                wr_en = r_pend;
                priority if (r_ptr != r_count) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr[AW-1:0];
                    n_wa    = ptr_dec[AW-1:0];
                    n_ptr   = ptr_inc;
                    n_pend  = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESULT;
                end
            end
            S_TRAV_RD: begin
                rd_en   = 1'b1;
                n_state = S_TRAV_WT;
            end
            S_TRAV_WT: begin
                out_next.status    = ST_OK;
                out_next.out_value = rd_q;
                out_next.last      = (ptr_inc == r_count);
                if (out_free) begin
                    out_load = 1'b1;
                    n_ptr    = ptr_inc;
                    n_state  = (ptr_inc == r_count) ? S_IDLE : S_TRAV_RD;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            if (out_free) begin
                r_out_valid <= out_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_idx    <= n_idx;
        r_wa     <= n_wa;
        r_val    <= n_val;
        r_status <= n_status;
        if (out_load) begin
            r_out_word <= out_next;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`include "positional_list_store_unit_assert.svh"

    `PLSU_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY),
        "count above capacity")
    `PLSU_ASSERT_SAME(a_ins_ptr, i_clk, i_rst_n, r_state == S_INS, r_ptr >= r_idx,
        "insert shift passed its slot")
    `PLSU_ASSERT_SAME(a_del_ptr, i_clk, i_rst_n, r_state == S_DEL, r_ptr <= r_count,
        "delete shift ran past the tail")
    `PLSU_ASSERT_NEXT(a_full_keeps, i_clk, i_rst_n,
        in_accept && full && (i_in_word.func == FN_INS_FRONT || i_in_word.func == FN_INS_END),
        $stable(r_count), "full insert changed count")
    `PLSU_ASSERT_NEXT(a_result_done, i_clk, i_rst_n, r_state == S_RESULT && out_free,
        r_state == S_IDLE && o_out_valid && o_out_word.last, "single result word not delivered")

endmodule

/* tb/sv/positional_list_store_unit_tb.sv */
// Self-checking testbench for the positional list store unit.
module positional_list_store_unit_tb;
    import plsu_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;
    localparam int RANDOM_REQS  = 450;
    localparam int PHASE_LEN    = 50;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = LIST_CAP + 24;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    t_in_word                  request_q[$];
    t_out_word                 expected_q[$];
    logic signed [VALUE_W-1:0] list_vals[LIST_CAP];
    int                        list_len       = 0;
    int                        gen_len        = 0;
    int                        in_gap         = 0;
    int                        stall_left     = 0;
    int                        words_in       = 0;
    int                        words_out      = 0;
    int                        idle_cycles    = 0;
    int                        mismatch_count = 0;

    positional_list_store_unit #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mirror of the list contents, updated as each request word is accepted.
    function automatic void push_result(logic [STATUS_W-1:0] st,
                                        logic signed [VALUE_W-1:0] v, logic fin);
        t_out_word r;
        r.status        = st;
        r.out_value     = v;
        r.element_count = list_len[ECOUNT_W-1:0];
        r.last          = fin;
        expected_q.push_back(r);
    endfunction

    function automatic void open_slot(int idx, logic signed [VALUE_W-1:0] v);
        for (int i = list_len; i > idx; i--) list_vals[i] = list_vals[i - 1];
        list_vals[idx] = v;
        list_len++;
    endfunction

    function automatic void close_slot(int idx);
        for (int i = idx; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
        list_len--;
    endfunction

    function automatic void apply_request(t_in_word w);
        int                  p;
        logic [STATUS_W-1:0] st;
        p  = int'(w.position);
        st = ST_OK;
        case (w.func)
            FN_INS_FRONT, FN_INS_END: begin
                if (list_len >= LIST_CAP) st = ST_FULL;
                else open_slot((w.func == FN_INS_FRONT) ? 0 : list_len, w.item_value);
            end
            FN_INS_AT: begin
                // A bad position is reported ahead of a full list.
                if (p == 0 || p > list_len + 1) st = ST_BADPOS;
                else if (list_len >= LIST_CAP) st = ST_FULL;
                else open_slot(p - 1, w.item_value);
            end
            FN_DEL_FRONT, FN_DEL_END: begin
                if (list_len == 0) st = ST_EMPTY;
                else close_slot((w.func == FN_DEL_FRONT) ? 0 : list_len - 1);
            end
            FN_DEL_AT: begin
                if (p == 0 || p > list_len) st = ST_BADPOS;
                else close_slot(p - 1);
            end
            FN_TRAVERSE: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_len; i++)
                        push_result(ST_OK, list_vals[i], i == list_len - 1);
                    return;
                end
            end
            default: ;
        endcase
        push_result(st, '0, 1'b1);
    endfunction

    // Queues a request and tracks the element count it leaves, so that the
    // generator can aim positions at the valid range most of the time.
    function automatic void add_request(logic [FUNC_W-1:0] f,
                                        logic signed [VALUE_W-1:0] v, int p);
        t_in_word w;
        w.func       = f;
        w.item_value = v;
        w.position   = p[POS_W-1:0];
        request_q.push_back(w);
        case (f)
            FN_INS_FRONT, FN_INS_END: if (gen_len < LIST_CAP) gen_len++;
            FN_INS_AT: if (p >= 1 && p <= gen_len + 1 && gen_len < LIST_CAP) gen_len++;
            FN_DEL_FRONT, FN_DEL_END: if (gen_len > 0) gen_len--;
            FN_DEL_AT: if (p >= 1 && p <= gen_len) gen_len--;
            default: ;
        endcase
    endfunction

    // Every fourth stretch of 32 words runs with no idling at all.
    function automatic int pick_gap(int done);
        int r;
        if ((done / 32) % 4 == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    initial begin
        int                        r;
        int                        kind;
        int                        p;
        int                        p_hi;
        logic                      grow;
        logic                      is_ins;
        logic signed [VALUE_W-1:0] v;
        logic [FUNC_W-1:0]         f;

        // Empty-list corner cases, then the value extremes.
        add_request(FN_TRAVERSE, '0, 0);
        add_request(FN_DEL_FRONT, '0, 0);
        add_request(FN_DEL_END, '0, 0);
        add_request(FN_DEL_AT, '0, 1);
        add_request(FN_INS_AT, 32'sd5, 0);
        add_request(FN_INS_AT, 32'sd5, 2);
        add_request(FN_INS_AT, 32'sh80000000, 1);
        add_request(FN_INS_FRONT, 32'sh7fffffff, 0);
        add_request(FN_INS_END, -32'sd1, 31);
        add_request(FN_SPARE, $urandom, 31);
        add_request(FN_DEL_AT, '0, 0);
        add_request(FN_DEL_AT, '0, 4);
        add_request(FN_INS_AT, '0, 4);
        add_request(FN_TRAVERSE, '0, 0);
        while (gen_len < LIST_CAP)
            add_request(FN_INS_AT, $urandom, $urandom_range(1, gen_len + 1));
        // Full list: a bad position wins over full, then every insert is refused.
        add_request(FN_INS_AT, 32'sd1, LIST_CAP + 2);
        add_request(FN_INS_AT, 32'sd1, LIST_CAP + 1);
        add_request(FN_INS_FRONT, 32'sd1, 0);
        add_request(FN_INS_END, 32'sd1, 0);
        add_request(FN_TRAVERSE, '0, 0);
        add_request(FN_DEL_AT, '0, LIST_CAP + 1);
        add_request(FN_DEL_AT, '0, LIST_CAP);
        add_request(FN_DEL_AT, '0, 1);
        add_request(FN_DEL_END, '0, 0);
        add_request(FN_DEL_FRONT, '0, 0);

        // Alternate insert-heavy and delete-heavy phases so the list swings
        // between empty and full.
        grow = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % PHASE_LEN == 0) grow = !grow;
            case ($urandom_range(0, 9))
                0:       v = 32'sh80000000;
                1:       v = 32'sh7fffffff;
                2:       v = '0;
                default: v = $urandom;
            endcase
            r    = $urandom_range(0, 99);
            kind = $urandom_range(0, 2);
            is_ins = 1'b0;
            if (r < 8) begin
                f = FN_TRAVERSE;
            end else if (r < 10) begin
                f = FN_SPARE;
            end else if (r < (grow ? 75 : 38)) begin
                f = (kind == 0) ? FN_INS_FRONT : (kind == 1) ? FN_INS_END : FN_INS_AT;
                is_ins = 1'b1;
            end else begin
                f = (kind == 0) ? FN_DEL_FRONT : (kind == 1) ? FN_DEL_END : FN_DEL_AT;
            end
            p_hi = is_ins ? gen_len + 1 : ((gen_len > 0) ? gen_len : 1);
            if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 31);
            else p = $urandom_range(1, p_hi);
            add_request(f, v, p);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (request_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Request driver: the front of request_q is presented until accepted.
    always @(posedge i_clk) begin : drive_proc
        logic     nxt_valid;
        int       nxt_gap;
        t_in_word taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_gap   = in_gap;
            if (i_in_valid && !o_in_stall) begin
                taken = request_q.pop_front();
                apply_request(taken);
                words_in  <= words_in + 1;
                nxt_valid = 1'b0;
                nxt_gap   = pick_gap(words_in);
            end
            if (!nxt_valid) begin
                if (nxt_gap > 0) begin
                    nxt_gap--;
                end else if (request_q.size() != 0) begin
                    nxt_valid = 1'b1;
                    i_in_word <= request_q[0];
                end
            end
            i_in_valid <= nxt_valid;
            in_gap     <= nxt_gap;
        end
    end

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin : check_proc
        t_out_word want;
        logic      nxt_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                words_out <= words_out + 1;
                if (expected_q.size() == 0) begin
                    $display("%0t: result word expected none got status %0d value %0d count %0d last %0b",
                             $time, o_out_word.status, o_out_word.out_value,
                             o_out_word.element_count, o_out_word.last);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, o_out_word.status);
                    check_field("out_value", want.out_value, o_out_word.out_value);
                    check_field("element_count", want.element_count, o_out_word.element_count);
                    check_field("last", want.last, o_out_word.last);
                end
            end
            if (stall_left > 0) begin
                nxt_stall = 1'b1;
                stall_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(words_out);
                nxt_stall  = (stall_left > 0);
                if (nxt_stall) stall_left--;
            end else begin
                nxt_stall = 1'b0;
            end
            i_out_stall <= nxt_stall;
        end
    end

    // Watchdog: too long without any word moving on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

/* positional_list_store_unit.f */
+incdir+rtl
rtl/plsu_pkg.sv
rtl/positional_list_store_unit.sv
tb/sv/positional_list_store_unit_tb.sv
